>>> src/plcg_pkg.sv
// shared types and constants of the color gradient unit
`default_nettype none
package plcg_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 13;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int ACC_W      = CH_W + POS_W;
  localparam int DIV_STAGES = CH_W;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_COLOR = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    WRAP_CLAMP    = 2'd0,
    WRAP_PERIODIC = 2'd1,
    WRAP_LIMITED  = 2'd2,
    WRAP_UNUSED   = 2'd3
  } wrap_e;

  typedef struct packed {
    logic                       kind;
    logic [SLOT_W-1:0]          node_slot;
    logic [POS_W-1:0]           node_pos;
    logic [CH_W-1:0]            node_red;
    logic [CH_W-1:0]            node_green;
    logic [CH_W-1:0]            node_blue;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            from_fallback;
  } out_item_t;

endpackage
`default_nettype wire

>>> src/plcg_stream_if.sv
// valid/ready stream channel carrying one payload
`default_nettype none
interface plcg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/plcg_table.sv
// gradient node storage with parallel segment search and operand read ports
`default_nettype none
module plcg_table #(
  parameter int MAX_NODES = 8,
  parameter int IW = $clog2(MAX_NODES),
  parameter int NW = $clog2(MAX_NODES + 1)
) (
  input  wire                           clk_i,
  input  wire                           wr_en_i,
  input  wire  [IW-1:0]                 wr_idx_i,
  input  wire  [plcg_pkg::POS_W-1:0]    wr_pos_i,
  input  wire  [plcg_pkg::COLOR_W-1:0]  wr_color_i,
  input  wire  [plcg_pkg::POS_W-1:0]    t_i,
  input  wire  [NW-1:0]                 n_i,
  output logic                          found_o,
  output logic [IW-1:0]                 seg_o,
  output logic                          eq_o,
  input  wire  [IW-1:0]                 rd_l_i,
  input  wire  [IW-1:0]                 rd_r_i,
  output logic [plcg_pkg::POS_W-1:0]    pos_l_o,
  output logic [plcg_pkg::POS_W-1:0]    pos_r_o,
  output logic [plcg_pkg::COLOR_W-1:0]  color_l_o,
  output logic [plcg_pkg::COLOR_W-1:0]  color_r_o
);
  import plcg_pkg::*;

  logic [POS_W-1:0]   pos_q [MAX_NODES];
  logic [COLOR_W-1:0] color_q [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pos_q[wr_idx_i]   <= wr_pos_i;
      color_q[wr_idx_i] <= wr_color_i;
    end
  end

  // first enclosing segment wins
  always_comb begin
    found_o = 1'b0;
    seg_o   = '0;
    eq_o    = 1'b0;
    for (int i = MAX_NODES - 1; i >= 1; i--) begin
      if (i < int'(n_i) && pos_q[i-1] <= t_i && t_i <= pos_q[i]) begin
        found_o = 1'b1;
        seg_o   = IW'(i);
        eq_o    = (pos_q[i-1] == pos_q[i]);
      end
    end
  end

  assign pos_l_o   = pos_q[rd_l_i];
  assign pos_r_o   = pos_q[rd_r_i];
  assign color_l_o = color_q[rd_l_i];
  assign color_r_o = color_q[rd_r_i];

endmodule
`default_nettype wire

>>> src/plcg_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module plcg_div (
  input  wire                         clk_i,
  input  wire                         en_i,
  input  wire  [plcg_pkg::ACC_W-1:0]  num_i,
  input  wire  [plcg_pkg::POS_W-1:0]  den_i,
  output logic [plcg_pkg::CH_W-1:0]   quo_o
);
  import plcg_pkg::*;

  logic [ACC_W-1:0] rem_q [DIV_STAGES];
  logic [POS_W-1:0] den_q [DIV_STAGES];
  logic [CH_W-1:0]  quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [ACC_W-1:0] rem_in;
    logic [POS_W-1:0] den_in;
    logic [CH_W-1:0]  quo_in;
    logic [ACC_W-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = ACC_W'(den_in) << (DIV_STAGES - 1 - s);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (rem_in >= trial) begin
          rem_q[s] <= rem_in - trial;
          quo_q[s] <= quo_in | (CH_W'(1) << (DIV_STAGES - 1 - s));
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> src/piecewise_linear_color_gradient_unit.sv
// top level of the piecewise linear color gradient unit
`default_nettype none
// Maps a signed Q3.12 sample to an RGB888 color through up to MAX_NODES gradient
// nodes written by load transactions (kind 0); lookup transactions (kind 1) give
// one result each, load transactions none. The pipeline takes one transaction per
// clock while it is not stalled, and a lookup result is offered after passing through
// thirteen register stages: five for shaping, segment search with operand read,
// operand differences and the two-step multiply, then eight stages of the
// per-channel divider, one quotient bit each. The whole pipeline stalls together
// when the output register is full and not taken. Nodes must be written before
// they are read.
module piecewise_linear_color_gradient_unit #(
  parameter int MAX_NODES = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [plcg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [plcg_pkg::COLOR_W-1:0]     cfg_data_i,
  plcg_stream_if.sink                      in_i,
  plcg_stream_if.source                    out_o
);
  import plcg_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = $clog2(MAX_NODES + 1);

  typedef enum logic [1:0] {
    RES_NODE,
    RES_MIX,
    RES_FB
  } res_e;

  wrap_e              wrap_q;
  logic [CNT_W-1:0]   count_q;
  logic [COLOR_W-1:0] fb_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q     <= WRAP_CLAMP;
      count_q    <= CNT_W'(2);
      fb_color_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WRAP_MODE:      wrap_q     <= wrap_e'(cfg_data_i[MODE_W-1:0]);
        CFG_NODE_COUNT:     count_q    <= cfg_data_i[CNT_W-1:0];
        CFG_FALLBACK_COLOR: fb_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic [DIV_STAGES-1:0] vd_q;
  logic [DIV_STAGES-1:0] fbd_q;

  assign adv      = !vd_q[DIV_STAGES-1] || out_o.ready;
  assign in_i.ready = adv;

  logic accept;
  assign accept = in_i.valid && adv;

  // node count in use
  logic [NW-1:0] n;
  always_comb begin
    if (int'(count_q) < 2) n = NW'(2);
    else if (int'(count_q) > MAX_NODES) n = NW'(MAX_NODES);
    else n = NW'(count_q);
  end

  // shaping
  logic signed [SAMPLE_W-1:0] s;
  logic [POS_W-1:0] t_d;
  logic             fb_d;
  logic             big;
  assign s   = in_i.payload.sample;
  assign big = s > $signed(SAMPLE_W'(ONE));

  always_comb begin
    t_d  = POS_W'(s);
    fb_d = 1'b0;
    case (wrap_q)
      WRAP_CLAMP: begin
        if (s[SAMPLE_W-1]) t_d = '0;
        else if (big) t_d = POS_W'(ONE);
      end
      WRAP_PERIODIC: begin
        t_d = POS_W'(s[FRAC_BITS-1:0]);
        if (s[SAMPLE_W-1] && (s[FRAC_BITS-1:0] != '0)) fb_d = 1'b1;
      end
      WRAP_LIMITED: begin
        if (s[SAMPLE_W-1] || big) fb_d = 1'b1;
      end
      default: fb_d = 1'b1;
    endcase
  end

  logic             v1_q, fb1_q;
  logic [POS_W-1:0] t1_q;

  // segment search and operand read
  logic             found, seg_eq;
  logic [IW-1:0]    seg;
  logic [POS_W-1:0] pos_l, pos_r;
  logic [COLOR_W-1:0] col_l, col_r;
  logic             wr_en;
  res_e             code_d;
  logic [IW-1:0]    l_d, r_d;

  assign wr_en = accept && !in_i.payload.kind &&
                 (32'(in_i.payload.node_slot) < MAX_NODES);

  plcg_table #(
    .MAX_NODES (MAX_NODES),
    .IW        (IW),
    .NW        (NW)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_idx_i   (IW'(in_i.payload.node_slot)),
    .wr_pos_i   (in_i.payload.node_pos),
    .wr_color_i ({in_i.payload.node_red, in_i.payload.node_green,
                  in_i.payload.node_blue}),
    .t_i        (t1_q),
    .n_i        (n),
    .found_o    (found),
    .seg_o      (seg),
    .eq_o       (seg_eq),
    .rd_l_i     (l_d),
    .rd_r_i     (r_d),
    .pos_l_o    (pos_l),
    .pos_r_o    (pos_r),
    .color_l_o  (col_l),
    .color_r_o  (col_r)
  );

  always_comb begin
    code_d = RES_NODE;
    l_d    = IW'(n - NW'(1));
    r_d    = l_d;
    if (fb1_q) begin
      code_d = RES_FB;
    end else if (t1_q == '0) begin
      l_d = '0;
    end else if (found) begin
      l_d = seg - IW'(1);
      r_d = seg;
      if (!seg_eq) code_d = RES_MIX;
    end
  end

  logic               v2_q;
  res_e               code2_q;
  logic [POS_W-1:0]   t2_q;
  logic [POS_W-1:0]   pos_l2_q, pos_r2_q;
  logic [COLOR_W-1:0] col_l2_q, col_r2_q;

  logic [POS_W-1:0]   den_d, k_d;
  logic [COLOR_W-1:0] cl_d;
  always_comb begin
    den_d = POS_W'(1);
    k_d   = '0;
    cl_d  = col_l2_q;
    case (code2_q)
      RES_MIX: begin
        den_d = pos_r2_q - pos_l2_q;
        k_d   = t2_q - pos_l2_q;
      end
      RES_FB:  cl_d = fb_color_q;
      default: ;
    endcase
  end

  logic               v3_q, fb3_q;
  logic [POS_W-1:0]   den3_q, k3_q;
  logic [COLOR_W-1:0] cl3_q, cr3_q;

  logic               v4_q, fb4_q;
  logic [POS_W-1:0]   den4_q;
  logic [ACC_W-1:0]   ml4_q [3];
  logic [ACC_W-1:0]   mr4_q [3];

  logic               v5_q, fb5_q;
  logic [POS_W-1:0]   den5_q;
  logic [ACC_W-1:0]   acc5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      vd_q  <= '0;
    end else if (adv) begin
      v1_q <= in_i.valid && in_i.payload.kind;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vd_q <= {vd_q[DIV_STAGES-2:0], v5_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q     <= t_d;
      fb1_q    <= fb_d;
      code2_q  <= code_d;
      pos_l2_q <= pos_l;
      pos_r2_q <= pos_r;
      col_l2_q <= col_l;
      col_r2_q <= col_r;
      t2_q     <= t1_q;
      fb3_q    <= (code2_q == RES_FB);
      den3_q   <= den_d;
      k3_q     <= k_d;
      cl3_q    <= cl_d;
      cr3_q    <= (code2_q == RES_MIX) ? col_r2_q : cl_d;
      fb4_q    <= fb3_q;
      den4_q   <= den3_q;
      for (int c = 0; c < 3; c++) begin
        ml4_q[c] <= ACC_W'(cl3_q[c*CH_W +: CH_W]) * ACC_W'(den3_q - k3_q);
        mr4_q[c] <= ACC_W'(cr3_q[c*CH_W +: CH_W]) * ACC_W'(k3_q);
        acc5_q[c] <= ml4_q[c] + mr4_q[c];
      end
      fb5_q    <= fb4_q;
      den5_q   <= den4_q;
      fbd_q    <= {fbd_q[DIV_STAGES-2:0], fb5_q};
    end
  end

  logic [CH_W-1:0] quo [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    plcg_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (acc5_q[c]),
      .den_i (den5_q),
      .quo_o (quo[c])
    );
  end

  assign out_o.valid                 = vd_q[DIV_STAGES-1];
  assign out_o.payload.red           = quo[2];
  assign out_o.payload.green         = quo[1];
  assign out_o.payload.blue          = quo[0];
  assign out_o.payload.from_fallback = fbd_q[DIV_STAGES-1];

endmodule
`default_nettype wire
